// ===== src/ufbd_pkg.sv =====
// Package for the fractional baud divider search.
// Field widths, sequencer states and divider sizes. No dependencies.
package ufbd_pkg;

  localparam int ClkW  = 27;
  localparam int BaudW = 22;
  localparam int DlW   = 16;
  localparam int FracW = 4;
  localparam int NumW  = 34;   // dividend width of the shared divider
  localparam int DenW  = 28;   // divisor width of the shared divider
  localparam int CntW  = 6;
  localparam int ErrW  = 28;

  localparam logic [ClkW-1:0]  ClockReset = ClkW'(48000000);
  localparam logic [DlW-1:0]   DlMax      = '1;
  localparam logic [FracW-1:0] MulLast    = 4'd15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAIN,
    S_PLAIN_RUN,
    S_DL,
    S_DL_RUN,
    S_RATE,
    S_RATE_RUN,
    S_NEXT,
    S_DONE
  } state_t;

endpackage

// ===== src/ufbd_if.sv =====
// Channel interfaces: requested baud rate in, divider setting out.
// Depends on ufbd_pkg for field widths.
interface ufbd_baud_if import ufbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BaudW-1:0] baud_rate;
  modport source (output valid, output baud_rate, input ready);
  modport sink   (input valid, input baud_rate, output ready);
endinterface

interface ufbd_div_if import ufbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DlW-1:0]   divisor_latch;
  logic [FracW-1:0] div_add;
  logic [FracW-1:0] mul;
  modport source (output valid, output divisor_latch, output div_add, output mul,
                  input ready);
  modport sink   (input valid, input divisor_latch, input div_add, input mul,
                  output ready);
endinterface

// ===== src/uart_fractional_baud_divider_search.sv =====
// Fractional baud divider search, top level with sequencer and shared divider.
// Depends on ufbd_pkg and the interfaces in ufbd_if.sv.
//
//   channel  dir  payload                          transfer
//   in       in   baud_rate[21:0]                  valid & ready
//   out      out  divisor_latch, div_add, mul      valid & ready
//   cfg      in   cfg_wdata[26:0] (clock_hz)       cfg_we
//
// One restoring divider (34/28 bits) does all work. An exact plain quotient
// needs no pair search. Otherwise it tries 120 pairs at two divisions each.
// in.ready is high only when idle. The result sits in an output register;
// the next item may be taken while it waits. Synchronous reset clears
// control and sets clock_hz to 48 MHz.
module uart_fractional_baud_divider_search import ufbd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [ClkW-1:0] cfg_wdata,
  ufbd_baud_if.sink       in,
  ufbd_div_if.source      out
);

  state_t state, state_next;

  logic [ClkW-1:0]  clock_hz;
  logic [BaudW-1:0] baud;
  logic [FracW-1:0] m, a;
  logic [DlW-1:0]   dl, best_dl;
  logic [FracW-1:0] best_add, best_mul;
  logic [ErrW-1:0]  err_min;
  logic             pmsb;

  // shared divider
  logic [NumW-1:0] dq;
  logic [DenW-1:0] dd;
  logic [DenW-1:0] dr;
  logic [CntW-1:0] cnt;
  logic            div_done;
  logic [DenW:0]   rsh;
  logic [DenW+1:0] diff;

  assign div_done = (cnt == '0);
  assign rsh      = {dr, dq[NumW-1]};
  assign diff     = {1'b0, rsh} - {2'b0, dd};

  // operands
  logic [FracW:0]  am;
  logic [31:0]     p;
  logic [26:0]     q;
  logic [30:0]     cm;
  logic [20:0]     dla;
  assign am  = {1'b0, a} + {1'b0, m};
  assign p   = 32'({m, 1'b0}) * 32'(clock_hz);
  assign q   = 27'(baud) * 27'(am);
  assign cm  = 31'(clock_hz) * 31'(m);
  assign dla = 21'(dl) * 21'(am);

  // candidate divisor from quotient
  logic [29:0] qs;
  logic [30:0] dl_r;
  logic [DlW-1:0] dl_sat, dl_cand;
  assign qs     = pmsb ? dq[NumW-1:4] : {1'b0, dq[NumW-1:5]};
  assign dl_r   = ({1'b0, qs} + 31'd1) >> 1;
  assign dl_sat = (dl_r > 31'(DlMax)) ? DlMax : dl_r[DlW-1:0];
  always_comb begin
    dl_cand = dl_sat;
    if (dl_cand == '0) dl_cand = 16'd1;
    if (a != '0 && dl_cand < 16'd2) dl_cand = 16'd2;
  end

  // actual rate and its error
  logic [28:0]     rate_r;
  logic [ErrW-1:0] rate, err;
  assign rate_r = ({1'b0, dq[27:0]} + 29'd1) >> 1;
  assign rate   = rate_r[ErrW-1:0];
  assign err    = (rate >= ErrW'(baud)) ? rate - ErrW'(baud) : ErrW'(baud) - rate;

  logic out_free;
  assign out_free = !out.valid || out.ready;
  assign in.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in.valid) state_next = (in.baud_rate == '0) ? S_DONE : S_PLAIN;
      S_PLAIN:     state_next = S_PLAIN_RUN;
      S_PLAIN_RUN: if (div_done) state_next = (dr != '0) ? S_DL : S_DONE;
      S_DL:        state_next = S_DL_RUN;
      S_DL_RUN:    if (div_done) state_next = S_RATE;
      S_RATE:      state_next = S_RATE_RUN;
      S_RATE_RUN:  if (div_done) state_next = S_NEXT;
      S_NEXT:      state_next = (am[FracW-1:0] == {m[FracW-2:0], 1'b0} - 4'd1 &&
                                 m == MulLast) ? S_DONE : S_DL;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clock_hz  <= ClockReset;
      cnt       <= '0;
      out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) clock_hz <= cfg_wdata;
      if (out.valid && out.ready && state != S_DONE) out.valid <= 1'b0;
      if (!div_done) begin
        cnt <= cnt - 1'b1;
        if (!diff[DenW+1]) begin
          dr <= diff[DenW-1:0];
          dq <= {dq[NumW-2:0], 1'b1};
        end else begin
          dr <= rsh[DenW-1:0];
          dq <= {dq[NumW-2:0], 1'b0};
        end
      end
      unique case (state)
        S_IDLE: if (in.valid) begin
          baud     <= in.baud_rate;
          best_dl  <= DlMax;
          best_add <= '0;
          best_mul <= 4'd1;
        end
        S_PLAIN: begin
          dq  <= NumW'(clock_hz);
          dd  <= DenW'({baud, 4'b0});
          dr  <= '0;
          cnt <= CntW'(NumW);
        end
        S_PLAIN_RUN: if (div_done) begin
          best_dl  <= (dq > NumW'(DlMax)) ? DlMax : dq[DlW-1:0];
          err_min  <= ErrW'(baud);
          m        <= 4'd1;
          a        <= '0;
        end
        S_DL: begin
          pmsb <= p[31];
          dq   <= p[31] ? {2'b0, p} : {1'b0, p, 1'b0};
          dd   <= DenW'(q);
          dr   <= '0;
          cnt  <= CntW'(NumW);
        end
        S_DL_RUN: if (div_done) dl <= dl_cand;
        S_RATE: begin
          dq  <= NumW'(cm);
          dd  <= DenW'({dla, 3'b0});
          dr  <= '0;
          cnt <= CntW'(NumW);
        end
        S_RATE_RUN: if (div_done && err < err_min) begin
          err_min  <= err;
          best_dl  <= dl;
          best_mul <= m;
          best_add <= a;
        end
        S_NEXT: begin
          if (a + 4'd1 < m) begin
            a <= a + 4'd1;
          end else begin
            a <= '0;
            m <= m + 4'd1;
          end
        end
        S_DONE: if (out_free) begin
          out.valid         <= 1'b1;
          out.divisor_latch <= (best_dl == '0) ? 16'd1 : best_dl;
          out.div_add       <= best_add;
          out.mul           <= best_mul;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/ufbd_checker.sv =====
// Port-level checks for the fractional baud divider search, with bind.
// Depends on ufbd_pkg and the top level's ports.
module ufbd_checker import ufbd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DlW-1:0]   divisor_latch,
  input logic [FracW-1:0] div_add,
  input logic [FracW-1:0] mul
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(divisor_latch) &&
    $stable(div_add) && $stable(mul)) else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after transfer");

  a_mul: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mul != '0 && div_add < mul) else $error("bad fractional pair");

  a_dl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> divisor_latch != '0 && (div_add == '0 || divisor_latch >= 16'd2))
    else $error("bad divisor");

endmodule

bind uart_fractional_baud_divider_search ufbd_checker u_ufbd_checker (
  .clk(clk), .rst(rst),
  .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .divisor_latch(out.divisor_latch), .div_add(out.div_add), .mul(out.mul)
);

// ===== verif/tb.sv =====
// Self-checking bench for the fractional baud divider search.
// Depends on ufbd_pkg, the channel interfaces in ufbd_if.sv and the top level.
module tb;
  import ufbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 40000;   // margin over one full search plus stalls

  typedef struct packed {
    logic [DlW-1:0]   divisor_latch;
    logic [FracW-1:0] div_add;
    logic [FracW-1:0] mul;
  } div_setting_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [ClkW-1:0] cfg_wdata = '0;

  ufbd_baud_if in_if ();
  ufbd_div_if  out_if ();

  uart_fractional_baud_divider_search u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in        (in_if),
    .out       (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [ClkW-1:0] uart_clock_hz = ClockReset;
  div_setting_t    pending_settings[$];
  int              mismatch_count = 0;
  int              settings_checked = 0;
  int              bauds_sent = 0;
  bit              sender_no_gaps = 1'b0;
  bit              receiver_no_stalls = 1'b0;
  bit              long_hold_req = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.baud_rate = '0;
    out_if.ready = 1'b0;
  end

  // Search the divisor latch and fractional pair for one requested rate.
  function automatic div_setting_t search_divider(longint unsigned clk_hz,
                                                  longint unsigned baud);
    div_setting_t    res;
    longint unsigned best_dl, best_add, best_mul, p, q, dl, rate;
    longint          err, err_min;
    best_add = 0;
    best_mul = 1;
    if (baud == 0) begin
      res.divisor_latch = DlMax;
      res.div_add = '0;
      res.mul = 4'd1;
      return res;
    end
    best_dl = clk_hz / (16 * baud);
    if (best_dl > 65535) best_dl = 65535;
    if (clk_hz % (16 * baud) != 0) begin
      err_min = longint'(baud);
      for (longint unsigned m = 1; m < 16; m++) begin
        for (longint unsigned a = 0; a < m; a++) begin
          p = 2 * m * clk_hz;
          q = baud * (a + m);
          if (p & 64'h8000_0000) dl = ((p / q) / 16 + 1) / 2;
          else dl = ((2 * p / q) / 32 + 1) / 2;
          if (dl > 65535) dl = 65535;
          if (dl == 0) dl = 1;
          if (a > 0 && dl < 2) dl = 2;
          rate = ((clk_hz * m / (dl * (a + m) * 8)) + 1) / 2;
          err = longint'(rate) - longint'(baud);
          if (err < 0) err = -err;
          if (err < err_min) begin
            err_min = err;
            best_dl = dl;
            best_mul = m;
            best_add = a;
          end
        end
      end
    end
    if (best_dl == 0) best_dl = 1;
    res.divisor_latch = best_dl[15:0];
    res.div_add = best_add[3:0];
    res.mul = best_mul[3:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // Send one baud rate; returns at the transfer edge, valid left high.
  task automatic send_baud(input logic [BaudW-1:0] baud);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.baud_rate <= baud;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    pending_settings.push_back(search_divider(64'(uart_clock_hz), 64'(baud)));
    bauds_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_uart_clock(input logic [ClkW-1:0] hz);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we <= 1'b0;
    uart_clock_hz = hz;
  endtask

  // Receiver: random stall per result, or one long hold-off on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (long_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        n = receiver_no_stalls ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Result checker.
  always @(posedge clk) begin
    div_setting_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_settings.size() == 0) begin
        report_mismatch("unexpected transfer, divisor_latch",
                        int'(out_if.divisor_latch), -1);
      end else begin
        want = pending_settings.pop_front();
        settings_checked++;
        if (out_if.divisor_latch !== want.divisor_latch)
          report_mismatch("divisor_latch", int'(out_if.divisor_latch),
                          int'(want.divisor_latch));
        if (out_if.div_add !== want.div_add)
          report_mismatch("div_add", int'(out_if.div_add), int'(want.div_add));
        if (out_if.mul !== want.mul)
          report_mismatch("mul", int'(out_if.mul), int'(want.mul));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no transfer for %0d cycles", IdleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_reset_clock();
    send_baud(22'd9600);
    send_baud(22'd115200);
    send_baud(22'd3000000);     // exact quotient of 1
    send_baud(22'd0);           // zero rate, slowest setting
    send_baud(22'd128);
    send_baud(22'd1);
    send_baud(22'h3FFFFF);      // clock below 16x rate
  endtask

  task automatic test_clock_extremes();
    set_uart_clock(27'h7FFFFFF);
    send_baud(22'd128);         // divisor saturates
    send_baud(22'd3000000);
    send_baud(22'h200000);
    send_baud(22'h3FFFFF);
    set_uart_clock(27'd1000000);
    send_baud(22'd62500);       // exact
    send_baud(22'd9600);
    send_baud(22'd3000000);     // zero plain quotient
    set_uart_clock(27'd0);
    send_baud(22'd9600);
    send_baud(22'd0);
    set_uart_clock(27'd1843200);
    send_baud(22'd115200);      // exact
    send_baud(22'd57600);
    send_baud(22'd1);
  endtask

  task automatic test_random_rates();
    int unsigned common_rates[8] = '{300, 1200, 9600, 19200, 38400, 57600,
                                     115200, 921600};
    for (int phase = 0; phase < 4; phase++) begin
      set_uart_clock(phase == 3 ? 27'h7FFFFFF :
                     ClkW'($urandom_range(1000000, 134217727)));
      sender_no_gaps = (phase == 1);
      receiver_no_stalls = (phase == 1);
      for (int i = 0; i < 18; i++) begin
        case ($urandom_range(0, 3))
          0: send_baud(BaudW'(common_rates[$urandom_range(0, 7)]));
          1: send_baud(BaudW'($urandom));
          default: send_baud(BaudW'($urandom_range(128, 3000000)));
        endcase
      end
    end
    sender_no_gaps = 1'b0;
    receiver_no_stalls = 1'b0;
  endtask

  // Exact rates keep each search short so the output side backs up.
  task automatic test_backpressure();
    int unsigned exact_rates[6] = '{3000000, 1500000, 1000000, 600000, 500000,
                                    300000};
    set_uart_clock(27'd48000000);
    sender_no_gaps = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 10; i++) send_baud(BaudW'(exact_rates[$urandom_range(0, 5)]));
    sender_no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_clock();
    test_clock_extremes();
    test_random_rates();
    test_backpressure();
    wait_drained();
    $display("Sent %0d baud requests over several clock settings, checked %0d settings.",
             bauds_sent, settings_checked);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
